/* hdl/nearest_neighbor_image_scaler_unit_assert.svh */
// Assertion macros shared by the scaler modules.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NNIS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NNIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/nnis_pkg.sv */
// Shared constants, types and helper functions of the image scaler.
package nnis_pkg;

    // Largest image dimension and copy limit per source pixel.
    localparam int MAX_DIM     = 1024;
    localparam int MAX_HCOPIES = 64;

    // Derived widths.
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int ERR_W = DIM_W + 1;
    localparam int CNT_W = $clog2(MAX_HCOPIES + 1);

    // Fixed field widths of the item payloads and configuration port.
    localparam int PIX_W     = 8;
    localparam int COL_W     = 10;
    localparam int ROW_W     = 10;
    localparam int REP_W     = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init;
        logic accept;
        logic rows_step;
        logic col_step;
        logic emit;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic src_col_zero;
        logic row_err_neg;
        logic col_err_neg;
        logic can_emit;
        logic slot_free;
    } sts_t;

    // Effective source size: zero acts as one, large values saturate.
    function automatic logic [DIM_W-1:0] clamp_src(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (int'(v) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        else
            r = DIM_W'(v);
        return r;
    endfunction

    // Effective destination size: zero follows the source size.
    function automatic logic [DIM_W-1:0] eff_dst(input logic [CFG_W-1:0] v,
                                                 input logic [DIM_W-1:0] src_eff);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = src_eff;
        else if (int'(v) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        else
            r = DIM_W'(v);
        return r;
    endfunction

endpackage

/* hdl/nnis_stream_if.sv */
// Handshake interfaces for the source pixel and result item channels.
interface nnis_pix_if
    import nnis_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface nnis_res_if
    import nnis_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic [COL_W-1:0] dest_col;
    logic [ROW_W-1:0] dest_row;
    logic [REP_W-1:0] row_repeat;
    logic             last_of_run;
    logic             frame_done;

    modport source (output valid, output pixel_out, output dest_col, output dest_row,
                    output row_repeat, output last_of_run, output frame_done,
                    input ready);
    modport sink   (input valid, input pixel_out, input dest_col, input dest_row,
                    input row_repeat, input last_of_run, input frame_done,
                    output ready);
endinterface

/* hdl/nnis_ctrl.sv */
// Controller state machine that sequences the row count and copy loops.
`include "nearest_neighbor_image_scaler_unit_assert.svh"

module nnis_ctrl
    import nnis_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_wr_en,
    input  logic in_valid,
    output logic in_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ROWS,
        S_COLS
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;

    assign in_ready = in_ready_reg;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.src_col_zero ? S_ROWS : S_COLS;
                end
            end
            S_ROWS:
            begin
                // Count destination rows for this line by repeated subtraction.
                if (sts.row_err_neg)
                    state_next = S_COLS;
                else
                    cmd.rows_step = 1'b1;
            end
            S_COLS:
            begin
                if (sts.col_err_neg)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!sts.can_emit)
                    cmd.col_step = 1'b1;
                else if (sts.slot_free)
                begin
                    cmd.col_step = 1'b1;
                    cmd.emit     = 1'b1;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
        // Any register write restarts the frame.
        if (cfg_wr_en)
        begin
            cmd        = '0;
            state_next = S_INIT;
        end
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    `NNIS_ASSERT_NOW(a_ready_only_idle, clk, rst_n, in_ready_reg, (state_reg == S_IDLE), "ready outside idle")
    `NNIS_ASSERT_NEXT(a_cfg_restarts, clk, rst_n, cfg_wr_en, (state_reg == S_INIT), "write did not restart")
    `NNIS_ASSERT_NEXT(a_accept_starts, clk, rst_n, (in_valid && in_ready_reg && !cfg_wr_en), (state_reg == S_ROWS || state_reg == S_COLS), "accepted item not started")

endmodule

/* hdl/nnis_dp.sv */
// Datapath: configuration registers, error terms, counters and output register.
`include "nearest_neighbor_image_scaler_unit_assert.svh"

module nnis_dp
    import nnis_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [PIX_W-1:0]     pixel_in,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    nnis_res_if.source           results
);

    // Configuration registers.
    logic [CFG_W-1:0] src_width_reg, src_width_next;
    logic [CFG_W-1:0] src_height_reg, src_height_next;
    logic [CFG_W-1:0] dst_width_reg, dst_width_next;
    logic [CFG_W-1:0] dst_height_reg, dst_height_next;

    // Scan state.
    logic signed [ERR_W-1:0] col_error_reg, col_error_next;
    logic signed [ERR_W-1:0] row_error_reg, row_error_next;
    logic [DIM_W-1:0] src_col_reg, src_col_next;
    logic [DIM_W-1:0] src_row_reg, src_row_next;
    logic [DIM_W-1:0] out_col_reg, out_col_next;
    logic [DIM_W-1:0] out_row_reg, out_row_next;
    logic [DIM_W-1:0] rows_reg, rows_next;
    logic [CNT_W-1:0] copies_reg, copies_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers.
    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] pixel_out_reg;
    logic [COL_W-1:0] dest_col_reg;
    logic [ROW_W-1:0] dest_row_reg;
    logic [REP_W-1:0] row_repeat_reg;
    logic             last_reg;
    logic             frame_done_reg;

    // Effective sizes and derived terms.
    logic [DIM_W-1:0]        sw, sh, dw, dh;
    logic signed [ERR_W-1:0] sw_e, sh_e, dw_e, dh_e;
    logic signed [ERR_W-1:0] col_err_step;
    logic                    row_end, frame_end, copy_last, copy_frame_done;

    assign sw   = clamp_src(src_width_reg);
    assign sh   = clamp_src(src_height_reg);
    assign dw   = eff_dst(dst_width_reg, sw);
    assign dh   = eff_dst(dst_height_reg, sh);
    assign sw_e = $signed({1'b0, sw});
    assign sh_e = $signed({1'b0, sh});
    assign dw_e = $signed({1'b0, dw});
    assign dh_e = $signed({1'b0, dh});

    assign col_err_step = col_error_reg - sw_e;
    assign row_end      = ({1'b0, src_col_reg} + 1'b1) >= {1'b0, sw};
    assign frame_end    = ({1'b0, src_row_reg} + 1'b1) >= {1'b0, sh};

    // The copy is last when the error runs out or the copy limit is reached.
    assign copy_last = col_err_step[ERR_W-1] || (copies_reg == CNT_W'(MAX_HCOPIES - 1));
    assign copy_frame_done = (({1'b0, out_col_reg} + 1'b1) == {1'b0, dw})
                          && (({1'b0, out_row_reg} + {1'b0, rows_reg}) == {1'b0, dh});

    // Status to the controller.
    always_comb
    begin
        sts.src_col_zero = (src_col_reg == '0);
        sts.row_err_neg  = row_error_reg[ERR_W-1];
        sts.col_err_neg  = col_error_reg[ERR_W-1];
        sts.can_emit     = (rows_reg != '0) && (copies_reg < CNT_W'(MAX_HCOPIES));
        sts.slot_free    = !out_valid_reg || results.ready;
    end

    // Next-state logic of the scan.
    always_comb
    begin
        src_width_next  = src_width_reg;
        src_height_next = src_height_reg;
        dst_width_next  = dst_width_reg;
        dst_height_next = dst_height_reg;
        col_error_next  = col_error_reg;
        row_error_next  = row_error_reg;
        src_col_next    = src_col_reg;
        src_row_next    = src_row_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        rows_next       = rows_reg;
        copies_next     = copies_reg;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  src_width_next  = cfg_data;
                REG_SRC_HEIGHT: src_height_next = cfg_data;
                REG_DST_WIDTH:  dst_width_next  = cfg_data;
                REG_DST_HEIGHT: dst_height_next = cfg_data;
                default:        src_width_next  = src_width_reg;
            endcase
        end

        if (cmd.init)
        begin
            col_error_next = dw_e - ERR_W'(1);
            row_error_next = dh_e - ERR_W'(1);
            src_col_next   = '0;
            src_row_next   = '0;
            out_col_next   = '0;
            out_row_next   = '0;
            rows_next      = '0;
            copies_next    = '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                copies_next = '0;
                if (src_col_reg == '0)
                    rows_next = '0;
            end
            if (cmd.rows_step)
            begin
                rows_next      = rows_reg + 1'b1;
                row_error_next = row_error_reg - sh_e;
            end
            if (cmd.col_step)
            begin
                col_error_next = col_err_step;
                out_col_next   = out_col_reg + 1'b1;
                if (cmd.emit)
                    copies_next = copies_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                col_error_next = col_error_reg + dw_e;
                src_col_next   = src_col_reg + 1'b1;
                // End of a source row: move to the next line.
                if (row_end)
                begin
                    src_col_next   = '0;
                    col_error_next = dw_e - ERR_W'(1);
                    out_col_next   = '0;
                    out_row_next   = out_row_reg + rows_reg;
                    rows_next      = '0;
                    row_error_next = row_error_reg + dh_e;
                    src_row_next   = src_row_reg + 1'b1;
                    // End of the frame: start over as after reset.
                    if (frame_end)
                    begin
                        row_error_next = dh_e - ERR_W'(1);
                        src_row_next   = '0;
                        out_row_next   = '0;
                    end
                end
            end
        end

        // Output register: loaded on a copy, cleared when taken.
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= CFG_W'(1);
            src_height_reg <= CFG_W'(1);
            dst_width_reg  <= '0;
            dst_height_reg <= '0;
            col_error_reg  <= '0;
            row_error_reg  <= '0;
            src_col_reg    <= '0;
            src_row_reg    <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            rows_reg       <= '0;
            copies_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            src_width_reg  <= src_width_next;
            src_height_reg <= src_height_next;
            dst_width_reg  <= dst_width_next;
            dst_height_reg <= dst_height_next;
            col_error_reg  <= col_error_next;
            row_error_reg  <= row_error_next;
            src_col_reg    <= src_col_next;
            src_row_reg    <= src_row_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            rows_reg       <= rows_next;
            copies_reg     <= copies_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload of the input pixel and of the output item.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            pix_reg <= pixel_in;
        if (cmd.emit)
        begin
            pixel_out_reg  <= pix_reg;
            dest_col_reg   <= COL_W'(out_col_reg);
            dest_row_reg   <= ROW_W'(out_row_reg);
            row_repeat_reg <= REP_W'(rows_reg);
            last_reg       <= copy_last;
            frame_done_reg <= copy_frame_done;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.pixel_out   = pixel_out_reg;
    assign results.dest_col    = dest_col_reg;
    assign results.dest_row    = dest_row_reg;
    assign results.row_repeat  = row_repeat_reg;
    assign results.last_of_run = last_reg;
    assign results.frame_done  = frame_done_reg;

    `NNIS_ASSERT_NOW(a_emit_slot, clk, rst_n, cmd.emit, (!out_valid_reg || results.ready), "copy overwrote a waiting item")
    `NNIS_ASSERT_NOW(a_copy_limit, clk, rst_n, 1'b1, (copies_reg <= CNT_W'(MAX_HCOPIES)), "copy count above limit")
    `NNIS_ASSERT_NOW(a_emit_legal, clk, rst_n, cmd.emit, (rows_reg != '0 && !col_error_reg[ERR_W-1]), "copy without row or error budget")

endmodule

/* hdl/nearest_neighbor_image_scaler_unit.sv */
// Top level of the nearest-neighbor image scaler.
//
// Source pixels arrive in row-major order and are scaled to the configured
// destination size with Bresenham error terms; each result item carries a
// destination column, the first destination row of its line and a row repeat
// count, so a downstream writer duplicates the line. After reset or any
// register write the block restarts the frame in its init state before it
// takes a pixel. Once a pixel is accepted, the first pixel of a source row
// goes through the row count loop, which subtracts the source height once
// per cycle. Every pixel then spends one cycle per horizontal step, but a
// copy stalls while the output register still holds an item the sink has
// not taken (copies emitted, dropped past the 64-copy limit, or consumed on
// a skipped row), and ends with a closing step. The output register lets
// the next pixel be accepted while the last copy of the previous one is
// still waiting.
module nearest_neighbor_image_scaler_unit
    import nnis_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    nnis_pix_if.sink             pixels,
    nnis_res_if.source           results,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    assign pixels.ready = in_ready;

    // Sequencer.
    nnis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .in_valid  (pixels.valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Error terms, counters and output register.
    nnis_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (pixels.pixel_in),
        .cmd       (cmd),
        .sts       (sts),
        .results   (results)
    );

endmodule
